// ===== rtl/pur_pkg.sv =====
// Package for the picture unit register port.
// Holds function codes, controller states, command struct and address mirroring.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pur_pkg;

  localparam int VIDEO_BYTES_DEF = 16384;

  typedef enum logic [3:0] {
    F_CTRL_WR    = 4'd0,
    F_STATUS_RD  = 4'd1,
    F_OAMADDR_WR = 4'd2,
    F_OAMDATA_RD = 4'd3,
    F_OAMDATA_WR = 4'd4,
    F_SCROLL_WR  = 4'd5,
    F_ADDR_WR    = 4'd6,
    F_DATA_WR    = 4'd7,
    F_DATA_RD    = 4'd8,
    F_VBLANK     = 4'd9,
    F_PRERENDER  = 4'd10,
    F_NMI_ACK    = 4'd11
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic respond;
  } dp_cmd_t;

  function automatic logic [13:0] mirror_address(input logic [15:0] addr, input logic vert);
    logic [13:0] a;
    logic [13:0] r;
    a = addr[13:0];
    if (a < 14'h2400) begin
      r = a;
    end else if (a < 14'h2800) begin
      r = {(vert ? 4'b1001 : 4'b1000), a[9:0]};
    end else if (a < 14'h2C00) begin
      r = {(vert ? 4'b1000 : 4'b1010), a[9:0]};
    end else if (a < 14'h3000) begin
      r = {(vert ? 4'b1001 : 4'b1010), a[9:0]};
    end else if (a < 14'h3F00) begin
      r = {2'b10, a[11:0]};
    end else if (a < 14'h3F20) begin
      r = (a[1:0] == 2'b00) ? 14'h3F00 : a;
    end else begin
      r = {10'h3F1, a[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pur_ctrl.sv =====
// Controller state machine of the picture unit register port.
// Depends on pur_pkg for states and the datapath command struct.
`timescale 1ns / 1ps
`default_nettype none

module pur_ctrl
  import pur_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  output logic         done,
  output dp_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    done        = 1'b0;
    cmd.accept  = 1'b0;
    cmd.respond = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        busy        = 1'b1;
        done        = 1'b1;
        cmd.respond = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> done)
    else $error("accepted transaction did not produce a result strobe");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !busy)
    else $error("transaction taken while busy");

endmodule

`default_nettype wire

// ===== rtl/pur_datapath.sv =====
// Datapath of the picture unit register port: registers, sprite and video memory.
// Depends on pur_pkg for function codes, mirroring and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module pur_datapath
  import pur_pkg::*;
#(
  parameter int VIDEO_BYTES = VIDEO_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_cmd_t    cmd,
  input  wire logic [3:0] func,
  input  wire logic [7:0] bus_byte,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  output logic [7:0]      read_byte,
  output logic            nmi_line
);

  localparam int VA_W = $clog2(VIDEO_BYTES);

  logic [7:0]  video_memory [VIDEO_BYTES];
  logic [7:0]  sprite_memory [256];
  logic [255:0] sprite_valid;

  logic [15:0] video_address;
  logic [2:0]  fine_x;
  logic        second_write;
  logic [7:0]  sprite_index;
  logic [7:0]  control_byte;
  logic        vblank_flag;
  logic        nmi_pending;
  logic        vertical_mirroring;

  logic [3:0]  func_q;
  logic        status_q;
  logic        nmi_q;
  logic [7:0]  video_rd;
  logic [7:0]  sprite_rd;
  logic        sprite_rd_valid;

  logic [13:0]     video_slot;
  logic [VA_W-1:0] video_index;
  logic [15:0]     step;

  assign video_slot  = mirror_address(video_address, vertical_mirroring);
  assign video_index = video_slot[VA_W-1:0];
  assign step        = control_byte[2] ? 16'd32 : 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_mirroring <= 1'b0;
    end else if (cfg_wr_en) begin
      vertical_mirroring <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && func == F_DATA_WR) begin
      video_memory[video_index] <= bus_byte;
    end
    if (cmd.accept && func == F_DATA_RD) begin
      video_rd <= video_memory[video_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && func == F_OAMDATA_WR) begin
      sprite_memory[sprite_index] <= bus_byte;
    end
    if (cmd.accept && func == F_OAMDATA_RD) begin
      sprite_rd <= sprite_memory[sprite_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q   <= func;
      status_q <= vblank_flag;
      nmi_q    <= nmi_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_valid    <= '0;
      sprite_rd_valid <= 1'b0;
      video_address   <= 16'h2000;
      fine_x          <= 3'd0;
      second_write    <= 1'b0;
      sprite_index    <= 8'd0;
      control_byte    <= 8'd0;
      vblank_flag     <= 1'b0;
      nmi_pending     <= 1'b0;
    end else if (cmd.accept) begin
      sprite_rd_valid <= sprite_valid[sprite_index];
      case (func)
        F_CTRL_WR: begin
          control_byte  <= bus_byte;
          video_address <= (video_address & 16'hF3FF) | {4'd0, bus_byte[1:0], 10'd0};
        end
        F_STATUS_RD: begin
          vblank_flag  <= 1'b0;
          second_write <= 1'b0;
        end
        F_OAMADDR_WR: begin
          sprite_index <= bus_byte;
        end
        F_OAMDATA_WR: begin
          sprite_valid[sprite_index] <= 1'b1;
        end
        F_SCROLL_WR: begin
          if (!second_write) begin
            fine_x        <= bus_byte[2:0];
            video_address <= (video_address & 16'hFFE0) | {11'd0, bus_byte[7:3]};
          end else begin
            video_address <= (video_address & 16'h8C1F) | {1'b0, bus_byte[2:0], 2'b00,
                             bus_byte[7:3], 5'd0};
          end
          second_write <= ~second_write;
        end
        F_ADDR_WR: begin
          if (!second_write) begin
            video_address <= {bus_byte, 8'd0};
          end else begin
            video_address <= {video_address[15:8], bus_byte};
          end
          second_write <= ~second_write;
        end
        F_DATA_WR, F_DATA_RD: begin
          video_address <= video_address + step;
        end
        F_VBLANK: begin
          vblank_flag <= 1'b1;
          if (control_byte[7]) begin
            nmi_pending <= 1'b1;
          end
        end
        F_PRERENDER: begin
          vblank_flag <= 1'b0;
        end
        F_NMI_ACK: begin
          nmi_pending <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    read_byte = 8'd0;
    if (cmd.respond) begin
      case (func_q)
        F_STATUS_RD:  read_byte = {status_q, 7'd0};
        F_OAMDATA_RD: read_byte = sprite_rd_valid ? sprite_rd : 8'd0;
        F_DATA_RD:    read_byte = video_rd;
        default:      read_byte = 8'd0;
      endcase
    end
  end

  assign nmi_line = nmi_q;

  a_status_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && func == F_STATUS_RD |=> !vblank_flag && !second_write)
    else $error("status read did not clear vblank and toggle");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && func == F_NMI_ACK |=> !nmi_pending)
    else $error("nmi acknowledge did not clear pending flag");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.accept |=> $stable(video_address) && $stable(control_byte))
    else $error("address or control changed without a transaction");

endmodule

`default_nettype wire

// ===== rtl/picture_unit_register_port.sv =====
// Picture unit register port: one CPU register access or frame event per transaction.
// The result strobe (done) rises in the cycle after start is taken, for one cycle.
// No new transaction is taken until the current one has responded; busy is high during the response cycle,
// which the registered read of sprite and video memory needs. The receiver cannot stall.
// Reset (rst, synchronous): the port's control registers and sprite valid bits clear at once, no sweep.
// Depends on pur_pkg, pur_ctrl and pur_datapath.
`timescale 1ns / 1ps
`default_nettype none

module picture_unit_register_port
  import pur_pkg::*;
#(
  parameter int VIDEO_BYTES = VIDEO_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [3:0] func,
  input  wire logic [7:0] bus_byte,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  output logic            done,
  output logic [7:0]      read_byte,
  output logic            nmi_line
);

  dp_cmd_t cmd;

  pur_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  pur_datapath #(
    .VIDEO_BYTES (VIDEO_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .bus_byte    (bus_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .read_byte   (read_byte),
    .nmi_line    (nmi_line)
  );

endmodule

`default_nettype wire

// ===== verif/pur_checker.sv =====
// Port checker for the picture unit register port: tracks every accepted transaction,
// predicts the read byte and nmi line, and compares each strobed result in order.
// Depends on pur_pkg for the function codes.
`timescale 1ns / 1ps

module pur_checker
  import pur_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  logic [3:0]      func,
  input  logic [7:0]      bus_byte,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            done,
  input  logic [7:0]      read_byte,
  input  logic            nmi_line,
  output int unsigned     mismatches,
  output int unsigned     outstanding,
  output logic            video_read_ok
);

  typedef struct packed {
    logic [7:0] rdata;
    logic       nmi;
  } port_reply_t;

  port_reply_t predicted_replies[$];

  logic [7:0]  vram [16384];
  bit          vram_written [16384];
  logic [7:0]  sprite_ram [256];
  logic [15:0] video_addr;
  logic [2:0]  fine_x;
  logic        write_toggle;
  logic [7:0]  sprite_ptr;
  logic [7:0]  ctrl_reg;
  logic        vblank;
  logic        nmi_flag;
  logic        vertical;

  function automatic logic [13:0] fold_address(input logic [15:0] va, input logic vert);
    logic [13:0] a;
    a = va[13:0];
    if (a < 14'h2400) return a;
    if (a < 14'h2800) return a - 14'h2400 + (vert ? 14'h2400 : 14'h2000);
    if (a < 14'h2C00) return a - 14'h2800 + (vert ? 14'h2000 : 14'h2800);
    if (a < 14'h3000) return a - 14'h2C00 + (vert ? 14'h2400 : 14'h2800);
    if (a < 14'h3F00) return a - 14'h3000 + 14'h2000;
    if (a < 14'h3F20) return (a[1:0] == 2'b00) ? 14'h3F00 : a;
    return ((a - 14'h3F20) & 14'h000F) + 14'h3F10;
  endfunction

  function automatic port_reply_t apply_access(input logic [3:0] op, input logic [7:0] b);
    port_reply_t reply;
    logic [13:0] slot;
    reply.rdata = 8'h00;
    reply.nmi = nmi_flag;
    slot = fold_address(video_addr, vertical);
    case (op)
      F_CTRL_WR: begin
        ctrl_reg = b;
        video_addr[11:10] = b[1:0];
      end
      F_STATUS_RD: begin
        reply.rdata = {vblank, 7'b0};
        vblank = 1'b0;
        write_toggle = 1'b0;
      end
      F_OAMADDR_WR: sprite_ptr = b;
      F_OAMDATA_RD: reply.rdata = sprite_ram[sprite_ptr];
      F_OAMDATA_WR: sprite_ram[sprite_ptr] = b;
      F_SCROLL_WR: begin
        if (!write_toggle) begin
          fine_x = b[2:0];
          video_addr = {video_addr[15:5], b[7:3]};
        end else begin
          video_addr = (video_addr & 16'h8C1F) | {1'b0, b[2:0], 12'b0} | {6'b0, b[7:3], 5'b0};
        end
        write_toggle = ~write_toggle;
      end
      F_ADDR_WR: begin
        if (!write_toggle) video_addr = {b, 8'h00};
        else video_addr = {video_addr[15:8], b};
        write_toggle = ~write_toggle;
      end
      F_DATA_WR: begin
        vram[slot] = b;
        vram_written[slot] = 1'b1;
        video_addr = video_addr + (ctrl_reg[2] ? 16'd32 : 16'd1);
      end
      F_DATA_RD: begin
        reply.rdata = vram[slot];
        video_addr = video_addr + (ctrl_reg[2] ? 16'd32 : 16'd1);
      end
      F_VBLANK: begin
        vblank = 1'b1;
        if (ctrl_reg[7]) nmi_flag = 1'b1;
      end
      F_PRERENDER: vblank = 1'b0;
      F_NMI_ACK: nmi_flag = 1'b0;
      default: ;
    endcase
    return reply;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 100)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track_port
    port_reply_t want;
    if (rst) begin
      for (int i = 0; i < 16384; i++) vram_written[i] = 1'b0;
      for (int i = 0; i < 256; i++) sprite_ram[i] = 8'h00;
      video_addr = 16'h2000;
      fine_x = 3'd0;
      write_toggle = 1'b0;
      sprite_ptr = 8'h00;
      ctrl_reg = 8'h00;
      vblank = 1'b0;
      nmi_flag = 1'b0;
      vertical = 1'b0;
      mismatches = 0;
      predicted_replies.delete();
    end else begin
      if (done) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("result with no transaction pending", read_byte, 8'h00);
        end else begin
          want = predicted_replies.pop_front();
          if (read_byte !== want.rdata) report_mismatch("read_byte", read_byte, want.rdata);
          if (nmi_line !== want.nmi) report_mismatch("nmi_line", {7'b0, nmi_line}, {7'b0, want.nmi});
        end
      end
      if (cfg_wr_en) vertical = cfg_wr_data;
      if (start && !busy) predicted_replies.push_back(apply_access(func, bus_byte));
    end
    outstanding <= predicted_replies.size();
    video_read_ok <= vram_written[fold_address(video_addr, vertical)];
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the register port testbench: clock, reset, directed and random transactions,
// mirroring changes between phases, watchdog and verdict.
// Depends on pur_pkg, picture_unit_register_port and pur_checker.
`timescale 1ns / 1ps

module testbench;
  import pur_pkg::*;

  localparam logic [3:0] F_SPARE_TOP = 4'hF;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES = 6;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [3:0] func = F_CTRL_WR;
  logic [7:0] bus_byte = 8'h00;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       busy;
  logic       done;
  logic [7:0] read_byte;
  logic       nmi_line;

  int unsigned mismatches;
  int unsigned outstanding;
  logic        video_read_ok;
  int unsigned sent = 0;
  int unsigned reads_sent = 0;
  int unsigned idle_cycles = 0;
  bit          steady = 1'b0;

  picture_unit_register_port uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .bus_byte(bus_byte),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .done(done),
    .read_byte(read_byte), .nmi_line(nmi_line)
  );

  pur_checker port_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .bus_byte(bus_byte),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .done(done),
    .read_byte(read_byte), .nmi_line(nmi_line), .mismatches(mismatches),
    .outstanding(outstanding), .video_read_ok(video_read_ok)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic pause_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!steady) begin
      if (roll >= 92) repeat ($urandom_range(8, 40)) @(posedge clk);
      else if (roll >= 60) repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    @(posedge clk);
  endtask

  // hold start until the transaction is taken; never read video memory that is unwritten
  task automatic issue(input logic [3:0] f, input logic [7:0] b);
    logic [3:0] op;
    pause_gap();
    op = f;
    if (op == F_DATA_RD && !video_read_ok) op = F_DATA_WR;
    start <= 1'b1;
    func <= op;
    bus_byte <= b;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    sent++;
    if (op == F_DATA_RD) reads_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_mirroring(input logic vert);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= vert;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic burst_video();
    logic [7:0] hi;
    logic [7:0] lo;
    int unsigned n;
    hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(8'h20 + $urandom_range(0, 31));
    lo = rand_byte();
    n = $urandom_range(1, 8);
    issue(F_CTRL_WR, rand_byte());
    issue(F_STATUS_RD, rand_byte());
    issue(F_ADDR_WR, hi);
    issue(F_ADDR_WR, lo);
    repeat (n) issue(F_DATA_WR, rand_byte());
    issue(F_ADDR_WR, hi);
    issue(F_ADDR_WR, lo);
    repeat (n) issue(F_DATA_RD, rand_byte());
  endtask

  task automatic burst_sprite();
    logic [7:0] ptr;
    ptr = rand_byte();
    issue(F_OAMADDR_WR, ptr);
    repeat ($urandom_range(1, 4)) issue(F_OAMDATA_WR, rand_byte());
    issue(F_OAMDATA_RD, rand_byte());
    issue(F_OAMADDR_WR, $urandom_range(0, 1) ? ptr : rand_byte());
    issue(F_OAMDATA_RD, rand_byte());
  endtask

  task automatic frame_events();
    issue(F_VBLANK, rand_byte());
    if ($urandom_range(0, 1)) issue(F_STATUS_RD, rand_byte());
    if ($urandom_range(0, 2) != 0) issue(F_NMI_ACK, rand_byte());
    issue(F_PRERENDER, rand_byte());
    issue(F_STATUS_RD, rand_byte());
  endtask

  task automatic scroll_pair();
    issue(F_STATUS_RD, rand_byte());
    issue(F_SCROLL_WR, rand_byte());
    issue(F_SCROLL_WR, rand_byte());
    if ($urandom_range(0, 1)) issue(F_DATA_WR, rand_byte());
  endtask

  initial begin
    int unsigned goal;
    int unsigned roll;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(F_CTRL_WR, 8'h80);
    issue(F_VBLANK, 8'h00);
    issue(F_STATUS_RD, 8'hFF);
    issue(F_NMI_ACK, 8'h00);
    issue(F_PRERENDER, 8'hFF);
    issue(F_STATUS_RD, 8'h00);
    issue(F_OAMADDR_WR, 8'hFF);
    issue(F_OAMDATA_WR, 8'hA5);
    issue(F_OAMDATA_RD, 8'h00);
    issue(F_SCROLL_WR, 8'hFF);
    issue(F_SCROLL_WR, 8'hFF);
    issue(F_ADDR_WR, 8'hFF);
    issue(F_ADDR_WR, 8'hFF);
    issue(F_DATA_WR, 8'h5A);
    issue(F_ADDR_WR, 8'h3F);
    issue(F_ADDR_WR, 8'h1F);
    issue(F_DATA_RD, 8'h00);
    issue(F_CTRL_WR, 8'h07);
    issue(F_DATA_WR, 8'h00);
    issue(F_DATA_RD, 8'hFF);
    issue(F_STATUS_RD, 8'h00);
    issue(F_SPARE_TOP, 8'hFF);
    issue(F_CTRL_WR, 8'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      set_mirroring(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      steady = (phase == 2);
      goal = sent + RANDOM_ITEMS / PHASES;
      while (sent < goal) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) burst_video();
        else if (roll < 50) burst_sprite();
        else if (roll < 62) frame_events();
        else if (roll < 70) scroll_pair();
        else issue(4'($urandom_range(0, 15)), rand_byte());
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Checked %0d transactions, %0d of them video reads, over %0d mirroring phases.",
             sent, reads_sent, PHASES);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
